// ===== src/get_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_pkg: shared types and constants of the graph edge table
// Field widths, action and status codes, controller commands and status,
// and the edge matching functions.
// ----------------------------------------------------------------------------
package get_pkg;

  // sizes of the stores
  localparam int unsigned MAX_EDGES_DEF    = 1024;
  localparam int unsigned MAX_VERTICES_DEF = 256;

  // field widths
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned VERTEX_W    = 8;
  localparam int unsigned WEIGHT_W    = 64;
  localparam int unsigned CURSOR_W    = 11;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned VCOUNT_W    = 9;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  // register reset values
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 9'd256;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_IS_DIRECTED  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 8'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD     = 3'd0,
    ACT_GET     = 3'd1,
    ACT_REMOVE  = 3'd2,
    ACT_REVERSE = 3'd3,
    ACT_NEXT    = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // edge store write kinds
  typedef enum logic [2:0] {
    WR_NONE,
    WR_UPDATE,
    WR_APPEND,
    WR_MOVE,
    WR_SWAP
  } wr_op_e;

  // result kinds
  typedef enum logic [2:0] {
    RES_MISS,
    RES_FULL,
    RES_OK,
    RES_GET,
    RES_NEXT
  } res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_REM_RD,
    S_REM_WR,
    S_REV,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VERTEX_W-1:0] start_vertex;
    logic [VERTEX_W-1:0] end_vertex;
    logic [WEIGHT_W-1:0] weight;
    logic [CURSOR_W-1:0] cursor;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WEIGHT_W-1:0] found_weight;
    logic [VERTEX_W-1:0] other_vertex;
    logic [INDEX_W-1:0]  edge_index;
  } result_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic   capture;
    logic   ptr_load;
    logic   ptr_from_cur;
    logic   scan_step;
    logic   rd_last;
    logic   hold_hit;
    wr_op_e wr_op;
    logic   cnt_inc;
    logic   cnt_dec;
    logic   res_set;
    res_e   res_kind;
    logic   out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic vok_pair;
    logic vok_start;
    logic directed;
    logic cur_past;
    logic chk_vld;
    logic ptr_end;
    logic full;
    logic find_hit;
    logic next_hit;
  } sts_t;

  // lookup match: loops match loops only, undirected takes either order
  function automatic logic find_match(input logic [VERTEX_W-1:0] a,
                                      input logic [VERTEX_W-1:0] b,
                                      input logic [VERTEX_W-1:0] s,
                                      input logic [VERTEX_W-1:0] e,
                                      input logic                directed);
    logic hit;
    if (s == e) begin
      hit = (a == s) && (b == s);
    end else if (directed) begin
      hit = (a == s) && (b == e);
    end else begin
      hit = ((a == s) && (b == e)) || ((a == e) && (b == s));
    end
    return hit;
  endfunction

  // next edge match: leaves the vertex, or touches it when undirected
  function automatic logic next_match(input logic [VERTEX_W-1:0] a,
                                      input logic [VERTEX_W-1:0] b,
                                      input logic [VERTEX_W-1:0] s,
                                      input logic                directed);
    return (a == s) || (!directed && (b == s));
  endfunction

endpackage

// ===== src/graph_edge_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_edge_table: edge table of a graph
// Stores start vertex, end vertex and a 64-bit weight per edge; adds,
// updates, looks up, removes, reverses and walks edges one action a word.
// ----------------------------------------------------------------------------
// One input word is handled at a time and gives one result word. The edge
// store is a single memory with one read port, and every lookup reads it
// one entry per cycle from index 0 (next edge from the cursor), so the time
// from one accepted word to the next follows the number of stored edges n
// for add, get, remove and reverse in a directed graph, and the walked span
// for next edge; words rejected at once skip the scan, and the result side
// can hold off further.
// The result sits in an output register, so the next word is taken while
// the previous result waits. Configuration writes are taken in any cycle
// and are meant to arrive only while the table is idle. The memory needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module graph_edge_table import get_pkg::*; #(
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  item_t                  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output result_t                out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // controller
  get_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_action_i (in_data_i.action),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  get_dp #(
    .MAX_EDGES    (MAX_EDGES),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // a taken word keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an accept");

  // no append into a full table
  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !sts.full)
    else $error("edge count grown past the table size");

  // the store is written only while a word is in work
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> cmd.wr_op == WR_NONE)
    else $error("edge store written while idle");

  // a taken result is not shown again
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !cmd.out_load |=> !out_valid_o)
    else $error("result word repeated");
`endif

endmodule

// ===== src/get_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_dp: datapath of the graph edge table
// Edge memory with one write and one registered read port, scan pointer,
// edge count, configuration registers, result and output registers.
// ----------------------------------------------------------------------------
module get_dp import get_pkg::*; #(
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  item_t                  in_data_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output result_t                out_data_o
);

  localparam int unsigned AW = $clog2(MAX_EDGES);
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EDGES);

  // configuration
  logic                directed_q;
  logic [VCOUNT_W-1:0] vcount_q;

  // item registers
  logic [VERTEX_W-1:0] s_q;
  logic [VERTEX_W-1:0] e_q;
  logic [WEIGHT_W-1:0] w_q;
  logic [CURSOR_W-1:0] cur_q;

  // scan and store control
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          chk_vld_q;
  logic [AW-1:0] chk_idx_q;
  logic [AW-1:0] hit_idx_q;
  logic [CW-1:0] last_idx;
  logic [31:0]   cur_ext;
  logic [31:0]   chk_idx_ext;

  // memory ports
  entry_t        mem [MAX_EDGES];
  entry_t        rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  result_t res_q, res_d;
  result_t out_q;
  logic [VERTEX_W-1:0] other_vertex;

  function automatic logic vertex_ok(input logic [VERTEX_W-1:0] v,
                                     input logic [VCOUNT_W-1:0] lim);
    return (32'(v) < 32'(lim)) && (32'(v) < MAX_VERTICES);
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      directed_q <= 1'b0;
      vcount_q   <= VCOUNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IS_DIRECTED:  directed_q <= cfg_data_i[0];
        CFG_VERTEX_COUNT: vcount_q   <= cfg_data_i[VCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q   <= in_data_i.start_vertex;
      e_q   <= in_data_i.end_vertex;
      w_q   <= in_data_i.weight;
      cur_q <= in_data_i.cursor;
    end
  end

  assign cur_ext     = 32'(cur_q);
  assign last_idx    = count_q - CW'(1);
  assign chk_idx_ext = 32'(chk_idx_q);

  // scan pointer and edge count
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_load) begin
      ptr_d = cmd_i.ptr_from_cur ? cur_ext[CW-1:0] : '0;
    end else if (cmd_i.scan_step) begin
      ptr_d = ptr_q + CW'(1);
    end
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      chk_vld_q <= cmd_i.scan_step;
    end
  end

  // index of the word now in the read register, and of the hit for remove
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      chk_idx_q <= ptr_q[AW-1:0];
    end
    if (cmd_i.hold_hit) begin
      hit_idx_q <= chk_idx_q;
    end
  end

  // read port select
  assign rd_en   = cmd_i.scan_step || cmd_i.rd_last;
  assign rd_addr = cmd_i.rd_last ? last_idx[AW-1:0] : ptr_q[AW-1:0];

  // write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = chk_idx_q;
    wr_data = rd_q;
    case (cmd_i.wr_op)
      WR_UPDATE: begin
        wr_data = '{src: rd_q.src, dst: rd_q.dst, weight: w_q};
      end
      WR_APPEND: begin
        wr_addr = count_q[AW-1:0];
        wr_data = '{src: s_q, dst: e_q, weight: w_q};
      end
      WR_MOVE: begin
        wr_addr = hit_idx_q;
      end
      WR_SWAP: begin
        wr_data = '{src: rd_q.dst, dst: rd_q.src, weight: rd_q.weight};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // edge memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // status towards the controller
  always_comb begin
    sts_o.vok_pair  = vertex_ok(s_q, vcount_q) && vertex_ok(e_q, vcount_q);
    sts_o.vok_start = vertex_ok(s_q, vcount_q);
    sts_o.directed  = directed_q;
    sts_o.cur_past  = cur_ext >= 32'(count_q);
    sts_o.chk_vld   = chk_vld_q;
    sts_o.ptr_end   = ptr_q >= count_q;
    sts_o.full      = count_q >= CNT_MAX;
    sts_o.find_hit  = chk_vld_q && find_match(rd_q.src, rd_q.dst, s_q, e_q, directed_q);
    sts_o.next_hit  = chk_vld_q && next_match(rd_q.src, rd_q.dst, s_q, directed_q);
  end

  assign other_vertex = (rd_q.src == s_q) ? rd_q.dst : rd_q.src;

  // result word
  always_comb begin
    res_d = '{status: ST_MISS, found_weight: '0, other_vertex: '0, edge_index: '0};
    case (cmd_i.res_kind)
      RES_FULL: res_d.status = ST_FULL;
      RES_OK:   res_d.status = ST_OK;
      RES_GET: begin
        res_d.status       = ST_OK;
        res_d.found_weight = rd_q.weight;
      end
      RES_NEXT: begin
        res_d.status       = ST_OK;
        res_d.found_weight = rd_q.weight;
        res_d.other_vertex = other_vertex;
        res_d.edge_index   = chk_idx_ext[INDEX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== src/get_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_ctrl: controller of the graph edge table
// Sequences each action over the datapath: decode, memory scan, remove
// move, reverse sweep and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module get_ctrl import get_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ACTION_W-1:0] in_action_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sts_t                sts_i,
  output cmd_t                cmd_o
);

  state_e  state_q, state_d;
  action_e act_q;
  logic    out_valid_q, out_valid_d;
  logic    hit;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_ADD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cmd_o.capture) begin
        act_q <= action_e'(in_action_i);
      end
    end
  end

  // hit of the word under check, by action
  assign hit = (act_q == ACT_NEXT) ? sts_i.next_hit : sts_i.find_hit;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.wr_op    = WR_NONE;
    cmd_o.res_kind = RES_MISS;
    in_ready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_d = S_FINISH;
        cmd_o.res_set = 1'b1;
        case (act_q)
          ACT_ADD, ACT_GET, ACT_REMOVE: begin
            if (sts_i.vok_pair) begin
              cmd_o.res_set  = 1'b0;
              cmd_o.ptr_load = 1'b1;
              state_d        = S_SCAN;
            end
          end
          ACT_NEXT: begin
            if (sts_i.vok_start && !sts_i.cur_past) begin
              cmd_o.res_set      = 1'b0;
              cmd_o.ptr_load     = 1'b1;
              cmd_o.ptr_from_cur = 1'b1;
              state_d            = S_SCAN;
            end
          end
          ACT_REVERSE: begin
            if (sts_i.directed) begin
              cmd_o.res_set  = 1'b0;
              cmd_o.ptr_load = 1'b1;
              state_d        = S_REV;
            end else begin
              cmd_o.res_kind = RES_OK;
            end
          end
          default: ;
        endcase
      end

      // one read issued per cycle, the previous word checked
      S_SCAN: begin
        cmd_o.scan_step = !sts_i.ptr_end;
        if (hit) begin
          cmd_o.scan_step = 1'b0;
          state_d         = S_FINISH;
          case (act_q)
            ACT_ADD: begin
              cmd_o.wr_op    = WR_UPDATE;
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = RES_OK;
            end
            ACT_GET: begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = RES_GET;
            end
            ACT_REMOVE: begin
              cmd_o.hold_hit = 1'b1;
              state_d        = S_REM_RD;
            end
            default: begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = RES_NEXT;
            end
          endcase
        end else if (!sts_i.chk_vld && sts_i.ptr_end) begin
          state_d       = S_FINISH;
          cmd_o.res_set = 1'b1;
          if (act_q == ACT_ADD) begin
            if (sts_i.full) begin
              cmd_o.res_kind = RES_FULL;
            end else begin
              cmd_o.wr_op    = WR_APPEND;
              cmd_o.cnt_inc  = 1'b1;
              cmd_o.res_kind = RES_OK;
            end
          end
        end
      end

      // fetch the last entry to fill the hole
      S_REM_RD: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_REM_WR;
      end

      S_REM_WR: begin
        cmd_o.wr_op    = WR_MOVE;
        cmd_o.cnt_dec  = 1'b1;
        cmd_o.res_set  = 1'b1;
        cmd_o.res_kind = RES_OK;
        state_d        = S_FINISH;
      end

      // read ahead, write back the swapped word behind
      S_REV: begin
        cmd_o.scan_step = !sts_i.ptr_end;
        if (sts_i.chk_vld) begin
          cmd_o.wr_op = WR_SWAP;
        end else if (sts_i.ptr_end) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RES_OK;
          state_d        = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
